// File: design/led_matrix_scan_controller_core_macros.svh
// Assertion macros for the LED matrix scan controller checker.
// Used by lmsc_checker.sv; no other dependencies.
`ifndef LED_MATRIX_SCAN_CONTROLLER_CORE_MACROS_SVH
`define LED_MATRIX_SCAN_CONTROLLER_CORE_MACROS_SVH

// next-cycle implication, off while in reset
`define LMSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lmsc: property violated");

// next-cycle implication, also checked through reset
`define LMSC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lmsc: property violated");

`endif

// File: design/lmsc_pkg.sv
// Shared types, codes and constants for the LED matrix scan controller.
// No dependencies; compiled first.
`default_nettype none

package lmsc_pkg;

  localparam int BANK_BYTES_DEF  = 256;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int OPCODE_W    = 2;
  localparam int BYTE_ADDR_W = 8;
  localparam int DATA_W      = 8;
  localparam int ROW_W       = 4;
  localparam int DUTY_W      = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_TYPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_ROWS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BUFFER = 3'd4;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SWAP  = 2'd2;

  localparam logic PANEL_SCAN16 = 1'b0;
  localparam logic PANEL_HUB12  = 1'b1;

  localparam logic       PANEL_RST  = PANEL_HUB12;
  localparam logic [5:0] STRIDE_RST = 6'd4;
  localparam logic [6:0] HEIGHT_RST = 7'd16;
  localparam logic [7:0] BRIGHT_RST = 8'd255;
  localparam logic       DBUF_RST   = 1'b0;

  localparam int STRIDE_MAX = 32;
  localparam int BANDS_MAX  = 4;

  typedef struct packed {
    logic [5:0] stride;
    logic [2:0] bands;
    logic       ok;
  } geom_t;

  typedef struct packed {
    logic              panel_type;
    logic [DUTY_W-1:0] brightness;
    logic              double_buffer;
    geom_t             geom;
  } cfg_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]    op;
    logic [BYTE_ADDR_W-1:0] addr;
    logic [DATA_W-1:0]      data;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/lmsc_if.sv
// Valid/ready channel interfaces for the scan controller's item and result streams.
// Depends on lmsc_pkg.
`default_nettype none

interface lmsc_in_if;
  import lmsc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [BYTE_ADDR_W-1:0] byte_address;
  logic [DATA_W-1:0]      write_data;

  modport source (output valid, opcode, byte_address, write_data, input ready);
  modport sink (input valid, opcode, byte_address, write_data, output ready);
endinterface

interface lmsc_out_if;
  import lmsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] shift_byte;
  logic [ROW_W-1:0]  row_address;
  logic [DUTY_W-1:0] oe_duty;
  logic              last;

  modport source (output valid, shift_byte, row_address, oe_duty, last, input ready);
  modport sink (input valid, shift_byte, row_address, oe_duty, last, output ready);
endinterface

`default_nettype wire

// File: design/lmsc_front.sv
// Front end: accepts items, folds the address into the bank, drops items with no effect.
// Depends on lmsc_pkg and lmsc_in_if.
`default_nettype none

module lmsc_front #(
  parameter int BANK_BYTES = lmsc_pkg::BANK_BYTES_DEF
) (
  lmsc_in_if.sink         in_ch,
  input  logic            geom_ok,
  input  logic            clearing,
  input  logic            q_full,
  output logic            push,
  output lmsc_pkg::cmd_t  push_cmd
);
  import lmsc_pkg::*;

  localparam int ADDR_SPAN = 1 << BYTE_ADDR_W;
  localparam int RED_STEPS = (ADDR_SPAN - 1) / BANK_BYTES;

  logic [BYTE_ADDR_W-1:0] addr_red;
  logic                   keep;

  assign in_ch.ready = !q_full && !clearing;

  always_comb begin
    addr_red = in_ch.byte_address;
    for (int i = 0; i < RED_STEPS; i++) begin
      if (addr_red >= BYTE_ADDR_W'(BANK_BYTES)) begin
        addr_red = addr_red - BYTE_ADDR_W'(BANK_BYTES);
      end
    end
  end

  always_comb begin
    case (in_ch.opcode)
      OP_WRITE: keep = 1'b1;
      OP_SWAP:  keep = 1'b1;
      OP_TICK:  keep = geom_ok;
      default:  keep = 1'b0;
    endcase
  end

  assign push          = in_ch.valid && in_ch.ready && keep;
  assign push_cmd.op   = in_ch.opcode;
  assign push_cmd.addr = addr_red;
  assign push_cmd.data = in_ch.write_data;

endmodule

`default_nettype wire

// File: design/lmsc_fifo.sv
// Command queue between front end and back end.
// Depends on lmsc_pkg.
`default_nettype none

module lmsc_fifo #(
  parameter int DEPTH = lmsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lmsc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output lmsc_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import lmsc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign pop_cmd = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: design/lmsc_back.sv
// Back end: frame store, bank swap, scan sequencer and result pipeline.
// Depends on lmsc_pkg and lmsc_out_if.
`default_nettype none

module lmsc_back #(
  parameter int BANK_BYTES = lmsc_pkg::BANK_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lmsc_pkg::cfg_t cfg,
  input  logic           swap_clear,
  input  logic           q_empty,
  input  lmsc_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           clearing,
  lmsc_out_if.source     out_ch
);
  import lmsc_pkg::*;

  localparam int MEM_DEPTH = 2 * BANK_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_STREAM = 2'd2;

  typedef struct packed {
    logic              invert;
    logic              reverse;
    logic              last;
    logic [ROW_W-1:0]  row;
    logic [DUTY_W-1:0] duty;
  } lane_info_t;

  function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    for (int i = 0; i < DATA_W; i++) begin
      r[i] = v[DATA_W-1-i];
    end
    return r;
  endfunction

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  logic [1:0]        state_r, state_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [3:0]        phase_r, phase_nxt;
  logic              swapped_r, swapped_nxt;
  logic [1:0]        b_r, b_nxt;
  logic [4:0]        x_r, x_nxt;
  logic [1:0]        k_r, k_nxt;

  logic              t_hub12_r, t_hub12_nxt;
  logic              t_bank_r, t_bank_nxt;
  logic [1:0]        t_nb_last_r, t_nb_last_nxt;
  logic              t_flip0_r, t_flip0_nxt;
  logic [5:0]        t_stride_r, t_stride_nxt;
  logic [4:0]        t_s_last_r, t_s_last_nxt;
  logic [ROW_W-1:0]  t_row_r, t_row_nxt;
  logic [DUTY_W-1:0] t_duty_r, t_duty_nxt;

  logic              s1_vld_r, s1_vld_nxt;
  lane_info_t        s1_info_r;
  logic [DATA_W-1:0] rd_data_r;
  logic              out_vld_r, out_vld_nxt;
  logic [DATA_W-1:0] out_byte_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [DUTY_W-1:0] out_duty_r;
  logic              out_last_r;

  logic              hub12;
  logic              draw_bank;
  logic              disp_bank;
  logic              s2_en;
  logic              issue;
  logic              final_item;
  logic              reversed;
  logic [6:0]        row7;
  logic [4:0]        col;
  logic [11:0]       off12;
  logic [7:0]        off;
  logic [AW-1:0]     rd_idx;
  logic              wr_en;
  logic [AW-1:0]     wr_idx;
  logic [DATA_W-1:0] wr_data;
  lane_info_t        info;
  logic [DATA_W-1:0] xform;

  assign hub12     = (cfg.panel_type == PANEL_HUB12);
  assign draw_bank = cfg.double_buffer & ~swapped_r;
  assign disp_bank = cfg.double_buffer & swapped_r;
  assign clearing  = (state_r == ST_CLEAR);
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;

  assign s2_en      = !out_vld_r || out_ch.ready;
  assign issue      = (state_r == ST_STREAM) && (s2_en || !s1_vld_r);
  assign final_item = (x_r == t_s_last_r) && (b_r == t_nb_last_r) &&
                      (!t_hub12_r || k_r == 2'd3);
  assign reversed   = t_hub12_r && (t_flip0_r ^ b_r[0]);

  // row in the canvas and byte column for the current scan position
  always_comb begin
    if (!t_hub12_r) begin
      row7 = {1'b0, b_r[0], 5'b0} + {3'b0, t_row_r};
    end else if (reversed) begin
      row7 = {1'b0, b_r, 4'b0} + 7'd3 + {3'b0, k_r, 2'b0} - {5'b0, t_row_r[1:0]};
    end else begin
      row7 = {1'b0, b_r, 4'b0} + 7'd12 + {5'b0, t_row_r[1:0]} - {3'b0, k_r, 2'b0};
    end
    col = reversed ? (t_s_last_r - x_r) : x_r;
  end

  assign off12  = {6'b0, t_stride_r} * {6'b0, row7[5:0]} + {7'b0, col};
  assign off    = off12[7:0];
  assign rd_idx = t_bank_r ? (AW'(BANK_BYTES) + AW'(off)) : AW'(off);

  assign info.invert  = !t_hub12_r;
  assign info.reverse = reversed;
  assign info.last    = final_item;
  assign info.row     = t_row_r;
  assign info.duty    = t_duty_r;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_idx  = clr_cnt_r;
      wr_data = '1;
    end else begin
      wr_en   = q_pop && (q_cmd.op == OP_WRITE);
      wr_idx  = draw_bank ? (AW'(BANK_BYTES) + AW'(q_cmd.addr)) : AW'(q_cmd.addr);
      wr_data = q_cmd.data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    phase_nxt     = phase_r;
    swapped_nxt   = swapped_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    k_nxt         = k_r;
    t_hub12_nxt   = t_hub12_r;
    t_bank_nxt    = t_bank_r;
    t_nb_last_nxt = t_nb_last_r;
    t_flip0_nxt   = t_flip0_r;
    t_stride_nxt  = t_stride_r;
    t_s_last_nxt  = t_s_last_r;
    t_row_nxt     = t_row_r;
    t_duty_nxt    = t_duty_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_pop) begin
          case (q_cmd.op)
            OP_SWAP: begin
              if (cfg.double_buffer) begin
                swapped_nxt = ~swapped_r;
              end
            end
            OP_TICK: begin
              state_nxt    = ST_STREAM;
              b_nxt        = '0;
              x_nxt        = '0;
              k_nxt        = '0;
              t_hub12_nxt  = hub12;
              t_bank_nxt   = disp_bank;
              t_flip0_nxt  = ~cfg.geom.bands[0];
              t_stride_nxt = cfg.geom.stride;
              t_s_last_nxt = 5'(cfg.geom.stride - 6'd1);
              if (hub12) begin
                t_nb_last_nxt = 2'(cfg.geom.bands - 3'd1);
                t_row_nxt     = {2'b0, phase_r[1:0]};
                t_duty_nxt    = cfg.brightness;
                phase_nxt     = {2'b0, phase_r[1:0] + 2'd1};
              end else begin
                t_nb_last_nxt = (cfg.geom.bands > 3'd2) ? 2'd1 : 2'd0;
                t_row_nxt     = phase_r;
                t_duty_nxt    = ~cfg.brightness;
                phase_nxt     = phase_r + 4'd1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        if (issue) begin
          if (t_hub12_r && k_r != 2'd3) begin
            k_nxt = k_r + 2'd1;
          end else begin
            k_nxt = '0;
            if (x_r == t_s_last_r) begin
              x_nxt = '0;
              b_nxt = b_r + 2'd1;
            end else begin
              x_nxt = x_r + 5'd1;
            end
          end
          if (final_item) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (swap_clear) begin
      swapped_nxt = 1'b0;
    end
  end

  assign s1_vld_nxt  = issue ? 1'b1 : (s2_en ? 1'b0 : s1_vld_r);
  assign out_vld_nxt = s2_en ? s1_vld_r : out_vld_r;

  always_comb begin
    if (s1_info_r.reverse) begin
      xform = bit_rev(rd_data_r);
    end else if (s1_info_r.invert) begin
      xform = ~rd_data_r;
    end else begin
      xform = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      phase_r   <= '0;
      swapped_r <= 1'b0;
      b_r       <= '0;
      x_r       <= '0;
      k_r       <= '0;
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      phase_r   <= phase_nxt;
      swapped_r <= swapped_nxt;
      b_r       <= b_nxt;
      x_r       <= x_nxt;
      k_r       <= k_nxt;
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_hub12_r   <= t_hub12_nxt;
    t_bank_r    <= t_bank_nxt;
    t_nb_last_r <= t_nb_last_nxt;
    t_flip0_r   <= t_flip0_nxt;
    t_stride_r  <= t_stride_nxt;
    t_s_last_r  <= t_s_last_nxt;
    t_row_r     <= t_row_nxt;
    t_duty_r    <= t_duty_nxt;
    if (issue) begin
      s1_info_r <= info;
    end
    if (s2_en && s1_vld_r) begin
      out_byte_r <= xform;
      out_row_r  <= s1_info_r.row;
      out_duty_r <= s1_info_r.duty;
      out_last_r <= s1_info_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.shift_byte  = out_byte_r;
  assign out_ch.row_address = out_row_r;
  assign out_ch.oe_duty     = out_duty_r;
  assign out_ch.last        = out_last_r;

endmodule

`default_nettype wire

// File: design/led_matrix_scan_controller_core.sv
// Top level of the HUB08/HUB12 LED panel scan controller.
// Depends on lmsc_pkg, lmsc_if, lmsc_front, lmsc_fifo and lmsc_back.
//
// Usage:
//   in_ch carries items: write a frame byte, refresh tick or bank swap.
//   out_ch carries one result per shifted byte; last marks the latch byte.
//   cfg_we/cfg_index/cfg_wdata write the five setup registers, one per edge.
// Throughput:
//   Writes and swaps: one per cycle while the back end is idle, not streaming.
//   A tick streams N bytes at one per cycle while out_ch.ready is high, where
//   N = stride * bands (HUB08, one band per 32 rows) or stride * height / 4
//   (HUB12); the single read port of the frame store sets the byte rate.
//   Each byte passes the read register, then the output register, to out_ch.
//   Items queue in a QUEUE_DEPTH deep queue while the back end streams.
// Reset:
//   Clears control state and config, then sweeps the frame store to 0xFF,
//   all 2 * BANK_BYTES bytes (512 by default); in_ch.ready stays low meanwhile.
// Stall:
//   When out_ch.ready is low the result is held in the output register and
//   the stream pauses; input items are still taken until the queue fills.
`default_nettype none

module led_matrix_scan_controller_core #(
  parameter int BANK_BYTES  = lmsc_pkg::BANK_BYTES_DEF,
  parameter int QUEUE_DEPTH = lmsc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lmsc_in_if.sink                         in_ch,
  lmsc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lmsc_pkg::*;

  localparam int LIM_BYTES = (BANK_BYTES < 256) ? BANK_BYTES : 256;
  localparam int LIM_BANDS = LIM_BYTES / 16;

  logic              panel_type_r;
  logic [5:0]        stride_r;
  logic [6:0]        height_r;
  logic [7:0]        brightness_r;
  logic              dbuf_r;

  logic [5:0]        s_eff;
  logic [2:0]        bands;
  logic [8:0]        area;
  cfg_t              cfg_s;
  logic              swap_clear;

  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_full;
  logic              q_pop;
  cmd_t              q_pop_cmd;
  logic              q_empty;
  logic              clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_type_r <= PANEL_RST;
      stride_r     <= STRIDE_RST;
      height_r     <= HEIGHT_RST;
      brightness_r <= BRIGHT_RST;
      dbuf_r       <= DBUF_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PANEL_TYPE:    panel_type_r <= cfg_wdata[0];
        CFG_STRIDE_BYTES:  stride_r     <= cfg_wdata[5:0];
        CFG_HEIGHT_ROWS:   height_r     <= cfg_wdata[6:0];
        CFG_BRIGHTNESS:    brightness_r <= (cfg_wdata == 8'd1) ? 8'd2 : cfg_wdata;
        CFG_DOUBLE_BUFFER: dbuf_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign swap_clear = cfg_we && (cfg_index == CFG_DOUBLE_BUFFER) && (cfg_wdata[0] != dbuf_r);

  always_comb begin
    s_eff = stride_r;
    if (stride_r == '0) begin
      s_eff = 6'd1;
    end else if (stride_r > 6'(STRIDE_MAX)) begin
      s_eff = 6'(STRIDE_MAX);
    end
    bands = height_r[6:4];
    if (bands == '0) begin
      bands = 3'd1;
    end else if (bands > 3'(BANDS_MAX)) begin
      bands = 3'(BANDS_MAX);
    end
    area = {3'b0, s_eff} * {6'b0, bands};
  end

  assign cfg_s.panel_type    = panel_type_r;
  assign cfg_s.brightness    = brightness_r;
  assign cfg_s.double_buffer = dbuf_r;
  assign cfg_s.geom.stride   = s_eff;
  assign cfg_s.geom.bands    = bands;
  assign cfg_s.geom.ok       = (area <= 9'(LIM_BANDS));

  lmsc_front #(
    .BANK_BYTES (BANK_BYTES)
  ) u_front (
    .in_ch    (in_ch),
    .geom_ok  (cfg_s.geom.ok),
    .clearing (clearing),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  lmsc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  lmsc_back #(
    .BANK_BYTES (BANK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_s),
    .swap_clear (swap_clear),
    .q_empty    (q_empty),
    .q_cmd      (q_pop_cmd),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// File: design/lmsc_checker.sv
// Port-level checks for the scan controller, attached to the top level by bind.
// Depends on led_matrix_scan_controller_core_macros.svh and the top level.
`default_nettype none

`include "led_matrix_scan_controller_core_macros.svh"

module lmsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_shift_byte,
  input logic [3:0] out_row_address,
  input logic [7:0] out_oe_duty,
  input logic       out_last
);

  // frame store sweep keeps the input closed right after reset
  `LMSC_ASSERT_NEXT_ALWAYS(a_closed_after_reset, clk, !rst_n, !in_ready)

  // a scan streams without gaps once its bytes start moving
  `LMSC_ASSERT_NEXT(a_no_gap_in_scan, clk, rst_n,
    out_valid && out_ready && !out_last, out_valid)

  `LMSC_ASSERT_NEXT(a_scan_fields_steady, clk, rst_n,
    out_valid && out_ready && !out_last,
    out_row_address == $past(out_row_address) && out_oe_duty == $past(out_oe_duty))

  `LMSC_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_valid && !out_ready,
    out_valid && $stable(out_shift_byte) && $stable(out_last))

endmodule

bind led_matrix_scan_controller_core lmsc_checker u_lmsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_shift_byte  (out_ch.shift_byte),
  .out_row_address (out_ch.row_address),
  .out_oe_duty     (out_ch.oe_duty),
  .out_last        (out_ch.last)
);

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for led_matrix_scan_controller_core: frame writes, scan ticks and
// bank swaps under several panel setups, each streamed byte checked against a scoreboard.
// Depends on lmsc_pkg, lmsc_if and the design sources.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lmsc_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_NONE = 2'd3;
  localparam int BANK          = BANK_BYTES_DEF;
  localparam int SETTLE_CYCLES = 32;
  localparam int LONG_HOLD     = 250;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_SHOWN     = 20;

  typedef struct packed {
    logic [DATA_W-1:0] shift_byte;
    logic [ROW_W-1:0]  row_address;
    logic [DUTY_W-1:0] oe_duty;
    logic              last;
  } scan_beat_t;

  class scan_scoreboard;
    logic [DATA_W-1:0] frame_mem [2*BANK];
    logic [3:0]        phase;
    logic              swapped;
    logic              panel;
    logic [5:0]        stride;
    logic [6:0]        height;
    logic [7:0]        bright;
    logic              dbuf;
    scan_beat_t        expected_q[$];
    int                errors = 0;
    int                checked = 0;
    int                items = 0;
    int                scans = 0;

    function new();
      foreach (frame_mem[i]) frame_mem[i] = 8'hFF;
      phase   = 4'd0;
      swapped = 1'b0;
      panel   = PANEL_RST;
      stride  = STRIDE_RST;
      height  = HEIGHT_RST;
      bright  = BRIGHT_RST;
      dbuf    = DBUF_RST;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PANEL_TYPE:    panel = val[0];
        CFG_STRIDE_BYTES:  stride = val[5:0];
        CFG_HEIGHT_ROWS:   height = val[6:0];
        CFG_BRIGHTNESS:    bright = (val == 8'd1) ? 8'd2 : val;
        CFG_DOUBLE_BUFFER: begin
          if (val[0] != dbuf) begin
            dbuf    = val[0];
            swapped = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function int eff_stride();
      int s;
      s = int'(stride);
      if (s == 0) s = 1;
      if (s > STRIDE_MAX) s = STRIDE_MAX;
      return s;
    endfunction

    function int eff_height();
      int h;
      h = int'(height) & ~15;
      if (h < 16) h = 16;
      if (h > 64) h = 64;
      return h;
    endfunction

    function int canvas_bytes();
      int n;
      n = eff_stride() * eff_height();
      return (n > BANK) ? BANK : n;
    endfunction

    function logic [7:0] shown_byte(int off);
      int bank;
      bank = dbuf ? int'(swapped) : 0;
      return frame_mem[bank * BANK + (off & (BANK - 1))];
    endfunction

    function logic [7:0] mirror(logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = v[7-i];
      return r;
    endfunction

    function void add_beat(logic [7:0] v, logic [3:0] row, logic [7:0] duty);
      expected_q.push_back({v, row, duty, 1'b0});
    endfunction

    function void stream_rows();
      int s, h, q, base, top, first;
      logic [7:0] duty;
      logic [3:0] rowsel;
      bit flip;
      scan_beat_t tail;
      s = eff_stride();
      h = eff_height();
      if (s * h > BANK || s * h > 256) return;
      first = expected_q.size();
      if (panel == PANEL_SCAN16) begin
        duty = 8'd255 - bright;
        for (int y = 0; y < h; y += 32) begin
          base = s * (y + int'(phase));
          for (int x = 0; x < s; x++) add_beat(~shown_byte(base + x), phase, duty);
        end
        phase = phase + 4'd1;
      end else begin
        rowsel = {2'b00, phase[1:0]};
        flip   = (h & 16) == 0;
        q      = 4 * s;
        for (int y = 0; y < h; y += 16) begin
          base = s * (y + int'(rowsel));
          top  = s * (y + 16 - int'(rowsel)) - 1;
          for (int x = 0; x < s; x++)
            for (int k = 3; k >= 0; k--)
              if (flip) add_beat(mirror(shown_byte(top - k * q - x)), rowsel, bright);
              else add_beat(shown_byte(base + k * q + x), rowsel, bright);
          flip = !flip;
        end
        phase = {2'b00, phase[1:0] + 2'd1};
      end
      if (expected_q.size() > first) begin
        tail      = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
        scans++;
      end
    endfunction

    function void note_item(cmd_t c);
      int draw;
      draw = dbuf ? int'(!swapped) : 0;
      items++;
      case (c.op)
        OP_WRITE: frame_mem[draw * BANK + (int'(c.addr) % BANK)] = c.data;
        OP_TICK:  stream_rows();
        OP_SWAP:  if (dbuf) swapped = !swapped;
        default: ;
      endcase
    endfunction

    task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    endtask

    task check_result(scan_beat_t got);
      scan_beat_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", got.shift_byte, 8'h00);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.shift_byte !== want.shift_byte)
        report_mismatch("shift_byte", got.shift_byte, want.shift_byte);
      if (got.row_address !== want.row_address)
        report_mismatch("row_address", {4'd0, got.row_address}, {4'd0, want.row_address});
      if (got.oe_duty !== want.oe_duty)
        report_mismatch("oe_duty", got.oe_duty, want.oe_duty);
      if (got.last !== want.last)
        report_mismatch("last", {7'd0, got.last}, {7'd0, want.last});
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    quiet_tail = 1'b0;
  bit                    hold_req = 1'b0;
  int                    cycle_count = 0;
  scan_scoreboard        board;

  lmsc_in_if  in_ch();
  lmsc_out_if out_ch();

  led_matrix_scan_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               board.expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_result({out_ch.shift_byte, out_ch.row_address, out_ch.oe_duty, out_ch.last});
  end

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [7:0] addr, logic [7:0] data);
    int gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.byte_address <= addr;
    in_ch.write_data   <= data;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    board.note_item({op, addr, data});
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic setup_panel(logic panel, logic [7:0] stride, logic [7:0] rows,
                             logic [7:0] level, logic dbuf);
    wait_drain();
    write_reg(CFG_PANEL_TYPE, {7'd0, panel});
    write_reg(CFG_STRIDE_BYTES, stride);
    write_reg(CFG_HEIGHT_ROWS, rows);
    write_reg(CFG_BRIGHTNESS, level);
    write_reg(CFG_DOUBLE_BUFFER, {7'd0, dbuf});
  endtask

  // mostly writes into the visible canvas, with ticks, swaps and the odd unused opcode
  task automatic random_items(int count);
    int span, pick;
    logic [7:0] addr;
    span = board.canvas_bytes();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      addr = 8'($urandom_range(0, 255));
      if (pick < 58) begin
        if ($urandom_range(0, 3) != 0) addr = 8'($urandom_range(0, span - 1));
        send_item(OP_WRITE, addr, 8'($urandom_range(0, 255)));
      end else if (pick < 84) begin
        send_item(OP_TICK, addr, 8'($urandom_range(0, 255)));
      end else if (pick < 93) begin
        send_item(OP_SWAP, addr, 8'($urandom_range(0, 255)));
      end else begin
        send_item(OP_NONE, addr, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin : stimulus
    board              = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = '0;
    in_ch.byte_address = '0;
    in_ch.write_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset setup: HUB12, 4 bytes by 16 rows, single bank
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_WRITE, 8'h00, 8'h00);
    send_item(OP_WRITE, 8'h0F, 8'h80);
    send_item(OP_WRITE, 8'h30, 8'h01);
    send_item(OP_WRITE, 8'h3F, 8'hA5);
    send_item(OP_WRITE, 8'hFF, 8'h5A);
    send_item(OP_NONE, 8'hFF, 8'hFF);
    send_item(OP_SWAP, 8'hAA, 8'h55);
    repeat (4) send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_items(10);

    // HUB08, brightness 1 stored as 2, double buffered
    setup_panel(PANEL_SCAN16, 8'd16, 8'd16, 8'd1, 1'b1);
    send_item(OP_WRITE, 8'h00, 8'h81);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_SWAP, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00);
    send_item(OP_WRITE, 8'hFF, 8'h00);
    send_item(OP_SWAP, 8'h00, 8'h00);
    send_item(OP_TICK, 8'h00, 8'h00);
    random_items(10);

    // four bands, first band reversed
    setup_panel(PANEL_HUB12, 8'd2, 8'd64, 8'd0, 1'b0);
    random_items(14);

    setup_panel(PANEL_SCAN16, 8'd4, 8'd64, 8'd255, 1'b0);
    random_items(8);
    wait_drain();
    random_items(8);

    // stride 0 and an oversized height get clamped
    setup_panel(PANEL_HUB12, 8'd0, 8'd127, 8'd128, 1'b1);
    random_items(14);

    // stride clamps to 32, canvas too large: ticks stream nothing
    setup_panel(PANEL_SCAN16, 8'hFF, 8'd5, 8'd2, 1'b0);
    random_items(10);

    // longest scans while the result side holds off
    setup_panel(PANEL_HUB12, 8'd16, 8'd16, 8'd77, 1'b1);
    hold_req = 1'b1;
    repeat (6) begin
      send_item(OP_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      send_item(OP_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    random_items(12);

    setup_panel(PANEL_SCAN16, 8'd8, 8'd32, 8'd254, 1'b1);
    random_items(14);

    quiet_tail = 1'b1;
    setup_panel(PANEL_HUB12, 8'd4, 8'd48, 8'd200, 1'b0);
    random_items(14);

    wait_drain();
    $display("covered %0d items and %0d scans, %0d bytes checked, %0d mismatches",
             board.items, board.scans, board.checked, board.errors);
    $display("both panel types, single and double banks, clamped and oversized geometry");
    if (board.errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
